@@ hdl/byte_ring_buffer_burst_defines.svh @@
// ----------------------------------------------------------------------------
// Byte ring buffer burst: assertion macros
// Clocked concurrent checks shared by the ring buffer RTL.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_BURST_DEFINES_SVH
`define BYTE_RING_BUFFER_BURST_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define BRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ring buffer check failed");

// Check that the consequent holds in the cycle after the antecedent
`define BRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring buffer check failed");

`endif

@@ hdl/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte ring buffer burst package
// Transaction types, default sizes and result codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

   // Default sizes
   localparam int CAPACITY_DEF = 1023;
   localparam int MAX_GET_DEF  = 64;

   // Request and result kinds
   localparam logic KIND_PUT = 1'b0;
   localparam logic KIND_GET = 1'b1;

   // Status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;

   // Request transaction
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       run_first;
      logic       run_last;
      logic [9:0] amount;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic       result_kind;
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       last;
      logic [9:0] free_space;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/byte_ring_buffer_burst.sv @@
// Put: taken while idle with the output register free; a run's status is registered the cycle after.
// Get: memory read, then output load held until the output is free, per emitted byte, up to
//   MAX_GET bytes (the store has one registered read port); no request taken meanwhile.
// Empty get: an ST_EMPTY result. Zero-count get on a non-empty ring: no result.
// Reset clears pointers, run flag, sequencer; free count set to CAPACITY; store not cleared.
// ----------------------------------------------------------------------------
// Byte ring buffer burst
// Circular byte store with run-checked puts and bounded burst gets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "byte_ring_buffer_burst_defines.svh"

module byte_ring_buffer_burst
   import brb_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int MAX_GET  = MAX_GET_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   localparam int SLOTS = CAPACITY + 1;
   localparam int PTR_W = $clog2(SLOTS);
   localparam int CMP_W = (PTR_W > 10) ? PTR_W : 10;
   localparam int REM_W = $clog2(MAX_GET + 1);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_type;

   // Byte store
   logic [7:0] mem [SLOTS];

   state_type        state_ff,    state_in;
   logic [PTR_W-1:0] wr_ptr_ff,   wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff,   rd_ptr_in;
   logic [PTR_W-1:0] free_ff,     free_in;
   logic             run_acc_ff,  run_acc_in;
   logic [REM_W-1:0] rem_ff,      rem_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff,      rsp_in;
   logic [7:0]       rdata_ff;

   logic             wr_en;
   logic             rd_en;
   logic             out_free;
   logic             req_take;
   logic [PTR_W-1:0] stored;
   logic [CMP_W-1:0] amount_ext;
   logic [CMP_W-1:0] stored_ext;
   logic [CMP_W-1:0] n_cmp;
   logic             acc_run;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && out_free;
   assign req_take   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Compare path: free space against run length, stored count against get count
   assign stored     = PTR_W'(CAPACITY) - free_ff;
   assign amount_ext = CMP_W'(req_data.amount);
   assign stored_ext = CMP_W'(stored);
   assign n_cmp      = (amount_ext < stored_ext) ? amount_ext : stored_ext;
   assign acc_run    = req_data.run_first ? (CMP_W'(free_ff) >= amount_ext) : run_acc_ff;

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      free_in      = free_ff;
      run_acc_in   = run_acc_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_data.kind == KIND_PUT) begin
                  // Store the byte when the run is open and a slot is free
                  if (acc_run && (free_ff != '0)) begin
                     wr_en     = 1'b1;
                     wr_ptr_in = (wr_ptr_ff == PTR_W'(CAPACITY)) ? '0 : wr_ptr_ff + 1'b1;
                     free_in   = free_ff - 1'b1;
                  end
                  if (req_data.run_last) begin
                     run_acc_in             = 1'b0;
                     rsp_valid_in           = 1'b1;
                     rsp_in.result_kind     = KIND_PUT;
                     rsp_in.out_byte        = 8'h00;
                     rsp_in.status          = acc_run ? ST_OK : ST_REJECT;
                     rsp_in.last            = 1'b1;
                     rsp_in.free_space      = 10'(free_in);
                  end else begin
                     run_acc_in = acc_run;
                  end
               end else begin
                  priority if (stored == '0) begin
                     rsp_valid_in           = 1'b1;
                     rsp_in.result_kind     = KIND_GET;
                     rsp_in.out_byte        = 8'h00;
                     rsp_in.status          = ST_EMPTY;
                     rsp_in.last            = 1'b1;
                     rsp_in.free_space      = 10'(free_ff);
                  end else if (n_cmp != '0) begin
                     // Clip the burst and start the read loop
                     rem_in   = (n_cmp > CMP_W'(MAX_GET)) ? REM_W'(MAX_GET) : REM_W'(n_cmp);
                     state_in = S_READ;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_READ: begin
            // Fetch the oldest byte and release its slot
            rd_en     = 1'b1;
            rd_ptr_in = (rd_ptr_ff == PTR_W'(CAPACITY)) ? '0 : rd_ptr_ff + 1'b1;
            free_in   = free_ff + 1'b1;
            rem_in    = rem_ff - 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            // Hand the fetched byte to the output register
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = KIND_GET;
               rsp_in.out_byte    = rdata_ff;
               rsp_in.status      = ST_OK;
               rsp_in.last        = (rem_ff == '0);
               rsp_in.free_space  = 10'(free_ff);
               state_in           = (rem_ff == '0) ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         free_ff      <= PTR_W'(CAPACITY);
         run_acc_ff   <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         free_ff      <= free_in;
         run_acc_ff   <= run_acc_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // Byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= req_data.data_byte;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
   end

   // Checks
   `BRB_ASSERT_NOW(a_free_bound, clock, reset, 1'b1, free_ff <= PTR_W'(CAPACITY))
   `BRB_ASSERT_NOW(a_busy_blocks, clock, reset, state_ff != S_IDLE, !req_ready)
   `BRB_ASSERT_NEXT(a_get_starts, clock, reset,
      req_take && (req_data.kind == KIND_GET) && (stored != '0) && (req_data.amount != '0),
      state_ff == S_READ)
   `BRB_ASSERT_NEXT(a_read_emits, clock, reset, state_ff == S_READ, state_ff == S_EMIT)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer burst testbench
// Drives put runs and get requests through the valid/ready channels with
// random gaps on both sides. A scoreboard keeps its own copy of the ring,
// predicts every status and burst byte, and checks each result in order.
// ----------------------------------------------------------------------------
module testbench;
   import brb_pkg::*;

   localparam int CAP       = CAPACITY_DEF;
   localparam int SLOTS     = CAP + 1;
   localparam int GET_LIMIT = MAX_GET_DEF;

   // Ring contents predictor and in-order result checker
   class ring_scoreboard;
      logic [7:0]  ring [SLOTS];
      int unsigned wr_slot = 0;
      int unsigned rd_slot = 0;
      bit          run_open = 1'b0;
      rsp_type     awaited_rsp [$];
      int          errors = 0;
      int          requests = 0;
      int          checked = 0;
      int          runs_stored = 0;
      int          runs_refused = 0;
      int          empty_gets = 0;

      function int unsigned level();
         return (wr_slot + SLOTS - rd_slot) % SLOTS;
      endfunction

      function int unsigned room();
         return CAP - level();
      endfunction

      // Queue one result; free space is taken after the action
      function void queue_rsp(logic kind, logic [7:0] b, logic [1:0] st, logic lst);
         rsp_type r;
         r.result_kind = kind;
         r.out_byte    = b;
         r.status      = st;
         r.last        = lst;
         r.free_space  = 10'(room());
         awaited_rsp.push_back(r);
      endfunction

      // Apply an accepted request to the ring and queue what it yields
      function void note_request(req_type r);
         int unsigned n;
         logic [7:0]  b;
         requests++;
         if (r.kind == KIND_PUT) begin
            if (r.run_first) run_open = (room() >= r.amount);
            if (run_open && room() > 0) begin
               ring[wr_slot] = r.data_byte;
               wr_slot = (wr_slot + 1) % SLOTS;
            end
            if (r.run_last) begin
               if (run_open) runs_stored++;
               else runs_refused++;
               queue_rsp(KIND_PUT, 8'h00, run_open ? ST_OK : ST_REJECT, 1'b1);
               run_open = 1'b0;
            end
         end else begin
            n = level();
            if (n == 0) begin
               empty_gets++;
               queue_rsp(KIND_GET, 8'h00, ST_EMPTY, 1'b1);
            end else begin
               if (r.amount < n) n = r.amount;
               if (n > GET_LIMIT) n = GET_LIMIT;
               for (int unsigned i = 0; i < n; i++) begin
                  b = ring[rd_slot];
                  rd_slot = (rd_slot + 1) % SLOTS;
                  queue_rsp(KIND_GET, b, ST_OK, (i + 1 == n));
               end
            end
         end
      endfunction

      function void compare(string field, logic [9:0] want, logic [9:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      // Match an accepted result against the oldest prediction
      function void check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (awaited_rsp.size() == 0) begin
            $error("result with nothing awaited: kind %0d byte %0d status %0d",
                   got.result_kind, got.out_byte, got.status);
            errors++;
            return;
         end
         want = awaited_rsp.pop_front();
         compare("result_kind", want.result_kind, got.result_kind);
         compare("out_byte", want.out_byte, got.out_byte);
         compare("status", want.status, got.status);
         compare("last", want.last, got.last);
         compare("free_space", want.free_space, got.free_space);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   ring_scoreboard ring_sb = new();
   bit             send_calm = 1'b0;
   bit             take_calm = 1'b0;

   always #5 clock = ~clock;

   byte_ring_buffer_burst #(
      .CAPACITY (CAP),
      .MAX_GET  (GET_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Offer one request after a random gap and hold it until accepted
   task automatic send(input logic kind, input logic [7:0] data, input logic first,
                       input logic lst, input logic [9:0] amount);
      req_type r;
      int      gap;
      r.kind      = kind;
      r.data_byte = data;
      r.run_first = first;
      r.run_last  = lst;
      r.amount    = amount;
      if ($urandom_range(0, 23) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      ring_sb.note_request(r);
   endtask

   // Send a put run of random bytes, optionally with gets mixed in
   task automatic send_run(input int len, input int declared, input bit mix_gets);
      for (int i = 0; i < len; i++) begin
         if (mix_gets && i > 0 && $urandom_range(0, 9) == 0)
            send(KIND_GET, 8'($urandom), 1'($urandom), 1'($urandom),
                 10'($urandom_range(0, 12)));
         send(KIND_PUT, 8'($urandom), (i == 0), (i == len - 1),
              (i == 0) ? 10'(declared) : 10'($urandom));
      end
   endtask

   // Result side: random stalls, one long hold-off to back the block up
   initial begin
      int gap;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 23) == 0) take_calm = !take_calm;
         gap = take_calm ? 0 : $urandom_range(0, 16);
         if (taken == 30) gap = 400;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         ring_sb.check_result(rsp_data);
         taken++;
      end
   end

   // Stimulus
   initial begin
      int made;
      int len;
      int declared;
      int pick;
      made = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty gets, run shapes, stray bytes, gets inside a run
      send(KIND_GET, 8'h00, 1'b0, 1'b0, 10'd1);
      send(KIND_GET, 8'hFF, 1'b1, 1'b1, 10'd0);
      send(KIND_PUT, 8'hFF, 1'b1, 1'b1, 10'd1);
      send(KIND_PUT, 8'h00, 1'b1, 1'b0, 10'd3);
      send(KIND_PUT, 8'hA5, 1'b0, 1'b0, 10'd0);
      send(KIND_PUT, 8'h5A, 1'b0, 1'b1, 10'h3FF);
      send(KIND_PUT, 8'h81, 1'b1, 1'b1, 10'd0);
      send(KIND_PUT, 8'h7E, 1'b0, 1'b0, 10'd5);
      send(KIND_PUT, 8'h18, 1'b0, 1'b1, 10'd5);
      send(KIND_PUT, 8'h01, 1'b1, 1'b0, 10'd1023);
      send(KIND_PUT, 8'h02, 1'b0, 1'b0, 10'd0);
      send(KIND_PUT, 8'h03, 1'b0, 1'b1, 10'd0);
      send(KIND_PUT, 8'h11, 1'b1, 1'b0, 10'd2);
      send(KIND_GET, 8'h00, 1'b0, 1'b0, 10'd2);
      send(KIND_PUT, 8'h22, 1'b0, 1'b1, 10'd0);
      send(KIND_GET, 8'h00, 1'b0, 1'b0, 10'd0);
      send(KIND_PUT, 8'h33, 1'b1, 1'b0, 10'd1);
      send(KIND_PUT, 8'h44, 1'b0, 1'b0, 10'd0);
      send(KIND_PUT, 8'h55, 1'b0, 1'b1, 10'd0);
      send(KIND_GET, 8'hFF, 1'b1, 1'b1, 10'd1023);
      send(KIND_GET, 8'hFF, 1'b0, 1'b0, 10'd512);

      // Random mix: mostly well-formed runs and gets, some noise
      while (made < 310) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            case ($urandom_range(0, 9))
               6: declared = len - 1;
               7: declared = 0;
               8, 9: declared = $urandom_range(0, 1023);
               default: declared = len;
            endcase
            send_run(len, declared, 1'b1);
            made += len;
         end else if (pick < 85) begin
            send(KIND_GET, 8'($urandom), 1'($urandom), 1'($urandom),
                 ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 20)));
            made++;
         end else begin
            send(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 10'($urandom));
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then let any stray output show up
      while (ring_sb.awaited_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Ran %0d requests and checked %0d results under random gaps and a long stall.",
               ring_sb.requests, ring_sb.checked);
      $display("Runs stored %0d, runs refused %0d, gets on an empty ring %0d.",
               ring_sb.runs_stored, ring_sb.runs_refused, ring_sb.empty_gets);
      if (ring_sb.errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
